### rtl/multi_queue_ring_fifo_assert.svh
// Assertion macros used by the checker file.
`ifndef MULTI_QUEUE_RING_FIFO_ASSERT_SVH
`define MULTI_QUEUE_RING_FIFO_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MQRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mqrf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MQRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mqrf assertion failed");

`endif

### rtl/mqrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqrf_pkg
// Types and fixed field widths of the multi-queue ring FIFO.
// ----------------------------------------------------------------------------
package mqrf_pkg;

    localparam int CMD_W   = 2;
    localparam int ID_W    = 8;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BADQ  = 2'd3
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } entry_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

### rtl/mqrf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqrf_in_if
// Command channel: push, pop or query on one queue.
// ----------------------------------------------------------------------------
interface mqrf_in_if;

    logic                         valid;
    logic                         ready;
    logic [mqrf_pkg::CMD_W-1:0]   command;
    logic [mqrf_pkg::ID_W-1:0]    queue_id;
    logic [mqrf_pkg::DATA_W-1:0]  chunk_data;
    logic                         chunk_last;

    modport source (
        output valid, command, queue_id, chunk_data, chunk_last,
        input  ready
    );

    modport sink (
        input  valid, command, queue_id, chunk_data, chunk_last,
        output ready
    );

endinterface

### rtl/mqrf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqrf_out_if
// Result channel: one beat per command.
// ----------------------------------------------------------------------------
interface mqrf_out_if;

    logic                          valid;
    logic                          ready;
    logic [mqrf_pkg::STAT_W-1:0]   status;
    logic [mqrf_pkg::DATA_W-1:0]   read_data;
    logic                          read_last;
    logic [mqrf_pkg::COUNT_W-1:0]  queue_count;
    logic                          queue_full;
    logic                          queue_empty;

    modport source (
        output valid, status, read_data, read_last, queue_count, queue_full,
               queue_empty,
        input  ready
    );

    modport sink (
        input  valid, status, read_data, read_last, queue_count, queue_full,
               queue_empty,
        output ready
    );

endinterface

### rtl/mqrf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqrf_store
// Entry storage for all queues: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mqrf_store #(
    parameter int ENTRIES = 128,
    parameter int AW      = 7
) (
    input  logic               clk,
    input  mqrf_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]      waddr,
    input  logic [AW-1:0]      raddr,
    input  mqrf_pkg::entry_t   wentry,
    output mqrf_pkg::entry_t   rentry
);

    mqrf_pkg::entry_t mem [ENTRIES];
    mqrf_pkg::entry_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wentry;
        end
        if (ctl.re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    assign rentry = rd_reg;

endmodule

### rtl/multi_queue_ring_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_ring_fifo
// Bank of NUM_QUEUES ring FIFOs of QUEUE_DEPTH chunk/last-flag entries each.
// ----------------------------------------------------------------------------
// req carries one command per beat (push, pop, query) naming queue 1..N.
// rsp returns exactly one beat per command, in order: status, popped chunk
// and last flag, and the queue's count and full/empty flags after the command.
// A command passes through the input register and then the result register.
// Throughput: one command per cycle while rsp moves, set by a single pass
// through the queue pointer registers and one access to the shared entry
// memory (write on push, registered read on pop).
// req stays ready while rsp holds a beat, as long as the input register is
// free or rsp moves; a stalled rsp holds its beat and stops the input
// register after one more command.
// Reset empties every queue (counts, heads, tails to zero) and drops both
// pipeline stages; entry memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module multi_queue_ring_fifo #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mqrf_in_if.sink    req,
    mqrf_out_if.source rsp
);

    localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW      = $clog2(ENTRIES);

    // input register
    logic                               s1_valid_reg;
    logic [mqrf_pkg::CMD_W-1:0]         s1_cmd_reg;
    logic [mqrf_pkg::ID_W-1:0]          s1_qid_reg;
    logic [mqrf_pkg::DATA_W-1:0]        s1_data_reg;
    logic                               s1_last_reg;

    // result register
    logic                               s2_valid_reg;
    mqrf_pkg::status_t                  s2_status_reg;
    logic                               s2_pop_reg;
    logic [mqrf_pkg::COUNT_W-1:0]       s2_count_reg;
    logic                               s2_full_reg;
    logic                               s2_empty_reg;

    // queue state
    logic [CW-1:0] cnt_reg  [NUM_QUEUES];
    logic [PW-1:0] head_reg [NUM_QUEUES];
    logic [PW-1:0] tail_reg [NUM_QUEUES];

    logic              s2_ready;
    logic              advance;
    logic              id_ok;
    logic [QW-1:0]     q;
    logic [CW-1:0]     cnt;
    logic [PW-1:0]     head;
    logic [PW-1:0]     tail;
    logic [PW-1:0]     head_next;
    logic [PW-1:0]     tail_next;
    logic              push_ok;
    logic              pop_ok;
    logic [CW-1:0]     cnt_next;
    mqrf_pkg::status_t status_next;

    mqrf_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    mqrf_pkg::entry_t   mem_wentry;
    mqrf_pkg::entry_t   mem_rentry;

    assign s2_ready  = !s2_valid_reg || rsp.ready;
    assign advance   = s1_valid_reg && s2_ready;
    assign req.ready = !s1_valid_reg || s2_ready;

    always_comb
    begin
        id_ok = (s1_qid_reg != '0)
             && (s1_qid_reg <= mqrf_pkg::ID_W'(NUM_QUEUES));
        q     = id_ok ? QW'(s1_qid_reg - mqrf_pkg::ID_W'(1)) : '0;
        cnt   = cnt_reg[q];
        head  = head_reg[q];
        tail  = tail_reg[q];

        head_next = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + PW'(1);
        tail_next = (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : tail + PW'(1);

        push_ok = id_ok && (s1_cmd_reg == mqrf_pkg::CMD_PUSH)
               && (cnt != CW'(QUEUE_DEPTH));
        pop_ok  = id_ok && (s1_cmd_reg == mqrf_pkg::CMD_POP) && (cnt != '0);

        if (push_ok)
        begin
            cnt_next = cnt + CW'(1);
        end
        else if (pop_ok)
        begin
            cnt_next = cnt - CW'(1);
        end
        else
        begin
            cnt_next = cnt;
        end

        priority if (!id_ok)
        begin
            status_next = mqrf_pkg::ST_BADQ;
        end
        else if ((s1_cmd_reg == mqrf_pkg::CMD_PUSH) && !push_ok)
        begin
            status_next = mqrf_pkg::ST_FULL;
        end
        else if ((s1_cmd_reg == mqrf_pkg::CMD_POP) && !pop_ok)
        begin
            status_next = mqrf_pkg::ST_EMPTY;
        end
        else
        begin
            status_next = mqrf_pkg::ST_OK;
        end

        mem_ctl.we      = advance && push_ok;
        mem_ctl.re      = advance && pop_ok;
        mem_waddr       = AW'(q) * AW'(QUEUE_DEPTH) + AW'(tail);
        mem_raddr       = AW'(q) * AW'(QUEUE_DEPTH) + AW'(head);
        mem_wentry.data = s1_data_reg;
        mem_wentry.last = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_cmd_reg  <= req.command;
            s1_qid_reg  <= req.queue_id;
            s1_data_reg <= req.chunk_data;
            s1_last_reg <= req.chunk_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            if (push_ok)
            begin
                tail_reg[q] <= tail_next;
                cnt_reg[q]  <= cnt_next;
            end
            if (pop_ok)
            begin
                head_reg[q] <= head_next;
                cnt_reg[q]  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_status_reg <= status_next;
            s2_pop_reg    <= pop_ok;
            s2_count_reg  <= id_ok ? mqrf_pkg::COUNT_W'(cnt_next) : '0;
            s2_full_reg   <= id_ok && (cnt_next == CW'(QUEUE_DEPTH));
            s2_empty_reg  <= id_ok && (cnt_next == '0);
        end
    end

    mqrf_store #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_store (
        .clk    (clk),
        .ctl    (mem_ctl),
        .waddr  (mem_waddr),
        .raddr  (mem_raddr),
        .wentry (mem_wentry),
        .rentry (mem_rentry)
    );

    assign rsp.valid       = s2_valid_reg;
    assign rsp.status      = s2_status_reg;
    assign rsp.read_data   = s2_pop_reg ? mem_rentry.data : '0;
    assign rsp.read_last   = s2_pop_reg & mem_rentry.last;
    assign rsp.queue_count = s2_count_reg;
    assign rsp.queue_full  = s2_full_reg;
    assign rsp.queue_empty = s2_empty_reg;

endmodule

### rtl/mqrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqrf_checker
// Port-level checks on the multi-queue ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_queue_ring_fifo_assert.svh"

module mqrf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [mqrf_pkg::STAT_W-1:0]  rsp_status,
    input logic [mqrf_pkg::DATA_W-1:0]  rsp_read_data,
    input logic [mqrf_pkg::COUNT_W-1:0] rsp_queue_count,
    input logic                         rsp_queue_full,
    input logic                         rsp_queue_empty
);

    logic badq_beat;
    logic badq_quiet;
    logic empty_beat;
    logic full_beat;
    logic req_beat;

    assign badq_beat  = rsp_valid && (rsp_status == mqrf_pkg::ST_BADQ);
    assign badq_quiet = (rsp_queue_count == '0) && !rsp_queue_full && !rsp_queue_empty
                     && (rsp_read_data == '0);
    assign empty_beat = rsp_valid && (rsp_status == mqrf_pkg::ST_EMPTY);
    assign full_beat  = rsp_valid && (rsp_status == mqrf_pkg::ST_FULL);
    assign req_beat   = req_valid && req_ready;

    // a result beat holds until taken
    `MQRF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // bad queue id reports nothing else
    `MQRF_ASSERT_IMPL(a_badq_zero, clk, rst_n, badq_beat, badq_quiet)

    // refused pop leaves queue empty and returns no data
    `MQRF_ASSERT_IMPL(a_empty_pop, clk, rst_n, empty_beat, rsp_queue_empty && (rsp_read_data == '0))

    // refused push only on a full queue
    `MQRF_ASSERT_IMPL(a_full_push, clk, rst_n, full_beat, rsp_queue_full && !rsp_queue_empty)

    // a fresh result beat comes from an accepted command, via the input register
    `MQRF_ASSERT_IMPL(a_rsp_source, clk, rst_n, $rose(rsp_valid), $past(req_beat, 2))

endmodule

bind multi_queue_ring_fifo mqrf_checker u_mqrf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_read_data   (rsp.read_data),
    .rsp_queue_count (rsp.queue_count),
    .rsp_queue_full  (rsp.queue_full),
    .rsp_queue_empty (rsp.queue_empty)
);
